@@ hdl/sfa_pkg.sv @@
`timescale 1ns / 1ps

package sfa_pkg;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NOSPACE = 2'd1,
      ST_ERROR   = 2'd2,
      ST_MOVED   = 2'd3
   } status_type;

   localparam logic REQ_CREATE = 1'b0;
   localparam logic REQ_DELETE = 1'b1;

   localparam logic REG_MEMORY_SIZE = 1'b0;
   localparam logic REG_FIT_STRATEGY = 1'b1;

   localparam logic FIT_BEST = 1'b0;

   localparam logic [31:0] MEMORY_SIZE_RESET = 32'd4096;

   typedef struct packed {
      logic        req_type;
      logic [15:0] owner_pid;
      logic [15:0] seg_ident;
      logic [31:0] seg_size;
   } req_item_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] seg_base;
      logic [31:0] moved_from;
      logic [31:0] moved_len;
      logic        last;
   } rsp_item_type;

   typedef struct packed {
      logic [15:0] owner;
      logic [15:0] ident;
      logic [31:0] base;
      logic [31:0] len;
   } slot_entry_type;

   typedef struct packed {
      logic       latch;
      logic       idx_clr;
      logic       idx_inc;
      logic       free_chk;
      logic       del_clr;
      logic       scan_init;
      logic       pass_init;
      logic       pick_chk;
      logic       hole_seg;
      logic       hole_tail;
      logic       comp_init;
      logic       comp_step;
      logic       place;
      logic       emit;
      status_type emit_status;
      logic       emit_base;
   } cmd_type;

   typedef struct packed {
      logic is_delete;
      logic idx_last;
      logic free_found;
      logic del_hit;
      logic have_cand;
      logic slot_valid;
      logic need_move;
      logic out_free;
      logic nospace;
      logic found;
   } stat_type;

endpackage

@@ hdl/sfa_ctrl.sv @@
`timescale 1ns / 1ps

module sfa_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  sfa_pkg::stat_type stat,
   output logic             busy,
   output sfa_pkg::cmd_type cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DEL_RD,
      S_DEL_EV,
      S_FREE,
      S_FREE_END,
      S_PASS_RD,
      S_PASS_EV,
      S_PASS_END,
      S_TAIL,
      S_DECIDE,
      S_COMP_RD,
      S_COMP_EV,
      S_PLACE,
      S_FINAL
   } state_type;

   state_type            state_ff, state_in;
   logic                 second_ff, second_in;
   sfa_pkg::status_type  final_ff, final_in;
   logic                 final_base_ff, final_base_in;

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in      = state_ff;
      second_in     = second_ff;
      final_in      = final_ff;
      final_base_in = final_base_ff;
      cmd           = '0;
      cmd.emit_status = sfa_pkg::ST_OK;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch   = 1'b1;
               cmd.idx_clr = 1'b1;
               state_in    = S_FREE;
            end
         end
         S_FREE: begin
            // delete shares the entry path, branch once the item is latched
            if (stat.is_delete) begin
               state_in = S_DEL_RD;
            end else begin
               cmd.free_chk = 1'b1;
               if (stat.idx_last) begin
                  state_in = S_FREE_END;
               end else begin
                  cmd.idx_inc = 1'b1;
               end
            end
         end
         S_DEL_RD: begin
            state_in = S_DEL_EV;
         end
         S_DEL_EV: begin
            if (stat.del_hit) begin
               cmd.del_clr   = 1'b1;
               final_in      = sfa_pkg::ST_OK;
               final_base_in = 1'b0;
               state_in      = S_FINAL;
            end else if (stat.idx_last) begin
               final_in      = sfa_pkg::ST_ERROR;
               final_base_in = 1'b0;
               state_in      = S_FINAL;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_DEL_RD;
            end
         end
         S_FREE_END: begin
            if (!stat.free_found) begin
               final_in      = sfa_pkg::ST_ERROR;
               final_base_in = 1'b0;
               state_in      = S_FINAL;
            end else begin
               cmd.scan_init = 1'b1;
               cmd.idx_clr   = 1'b1;
               second_in     = 1'b0;
               state_in      = S_PASS_RD;
            end
         end
         S_PASS_RD: begin
            state_in = S_PASS_EV;
         end
         S_PASS_EV: begin
            cmd.pick_chk = 1'b1;
            if (stat.idx_last) begin
               state_in = S_PASS_END;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_PASS_RD;
            end
         end
         S_PASS_END: begin
            if (stat.have_cand) begin
               cmd.hole_seg  = 1'b1;
               cmd.pass_init = 1'b1;
               cmd.idx_clr   = 1'b1;
               state_in      = S_PASS_RD;
            end else begin
               state_in = S_TAIL;
            end
         end
         S_TAIL: begin
            cmd.hole_tail = 1'b1;
            state_in      = S_DECIDE;
         end
         S_DECIDE: begin
            if (!second_ff && stat.nospace) begin
               final_in      = sfa_pkg::ST_NOSPACE;
               final_base_in = 1'b0;
               state_in      = S_FINAL;
            end else if (stat.found) begin
               state_in = S_PLACE;
            end else if (!second_ff) begin
               cmd.comp_init = 1'b1;
               cmd.idx_clr   = 1'b1;
               state_in      = S_COMP_RD;
            end else begin
               final_in      = sfa_pkg::ST_ERROR;
               final_base_in = 1'b0;
               state_in      = S_FINAL;
            end
         end
         S_COMP_RD: begin
            state_in = S_COMP_EV;
         end
         S_COMP_EV: begin
            if (!(stat.slot_valid && stat.need_move && !stat.out_free)) begin
               cmd.comp_step = 1'b1;
               if (stat.slot_valid && stat.need_move) begin
                  cmd.emit        = 1'b1;
                  cmd.emit_status = sfa_pkg::ST_MOVED;
               end
               if (stat.idx_last) begin
                  cmd.scan_init = 1'b1;
                  cmd.idx_clr   = 1'b1;
                  second_in     = 1'b1;
                  state_in      = S_PASS_RD;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = S_COMP_RD;
               end
            end
         end
         S_PLACE: begin
            cmd.place     = 1'b1;
            final_in      = sfa_pkg::ST_OK;
            final_base_in = 1'b1;
            state_in      = S_FINAL;
         end
         S_FINAL: begin
            if (stat.out_free) begin
               cmd.emit        = 1'b1;
               cmd.emit_status = final_ff;
               cmd.emit_base   = final_base_ff;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         second_ff     <= 1'b0;
         final_ff      <= sfa_pkg::ST_OK;
         final_base_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         second_ff     <= second_in;
         final_ff      <= final_in;
         final_base_ff <= final_base_in;
      end
   end

endmodule

@@ hdl/sfa_datapath.sv @@
`timescale 1ns / 1ps

module sfa_datapath #(
   parameter int SEGMENT_SLOTS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sfa_pkg::req_item_type req_data,
   input  logic [31:0]           memory_size,
   input  logic                  fit_strategy,
   input  sfa_pkg::cmd_type      cmd,
   output sfa_pkg::stat_type     stat,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output sfa_pkg::rsp_item_type rsp_data
);

   localparam int IDX_W = $clog2(SEGMENT_SLOTS);
   // compaction cursor can add up every slot length
   localparam int CUR_W = 33 + IDX_W;

   sfa_pkg::slot_entry_type mem [SEGMENT_SLOTS];
   sfa_pkg::slot_entry_type rd_ff;
   logic                    wr_en;
   logic [IDX_W-1:0]        wr_addr;
   sfa_pkg::slot_entry_type wr_data;

   logic [SEGMENT_SLOTS-1:0] valid_ff;
   sfa_pkg::req_item_type    item_ff;
   logic [IDX_W-1:0]         idx_ff;
   logic [IDX_W-1:0]         free_idx_ff;
   logic                     free_found_ff;

   logic [CUR_W-1:0] cursor_ff;
   logic [32:0]      total_ff;
   logic             found_ff;
   logic [31:0]      best_ff;
   logic [31:0]      best_base_ff;
   logic             have_prev_ff;
   logic [31:0]      prev_base_ff;
   logic [IDX_W-1:0] prev_idx_ff;
   logic             have_cand_ff;
   logic [31:0]      cand_base_ff;
   logic [31:0]      cand_len_ff;
   logic [IDX_W-1:0] cand_idx_ff;

   logic                  rsp_valid_ff;
   sfa_pkg::rsp_item_type rsp_ff;

   logic             cur_valid;
   logic             out_free;
   logic [CUR_W-1:0] seg_end;
   logic [CUR_W-1:0] base_ext;
   logic             gap;
   logic [31:0]      hs;
   logic             fit;
   logic             better;
   logic             after_prev;
   logic             before_cand;

   assign cur_valid = valid_ff[idx_ff];
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign base_ext  = CUR_W'(rd_ff.base);
   assign seg_end   = CUR_W'(cand_base_ff) + CUR_W'(cand_len_ff);

   always_comb begin
      gap = 1'b0;
      hs  = '0;
      if (cmd.hole_tail) begin
         gap = cursor_ff < CUR_W'(memory_size);
         hs  = memory_size - cursor_ff[31:0];
      end else begin
         gap = CUR_W'(cand_base_ff) > cursor_ff;
         hs  = cand_base_ff - cursor_ff[31:0];
      end
      fit = gap && (hs >= item_ff.seg_size);
      if (fit_strategy == sfa_pkg::FIT_BEST) begin
         better = !found_ff || (hs < best_ff);
      end else begin
         better = !found_ff || (hs > best_ff);
      end
   end

   // next slot in (base, slot) order after the previous one
   assign after_prev = !have_prev_ff || (rd_ff.base > prev_base_ff) ||
                       ((rd_ff.base == prev_base_ff) && (idx_ff > prev_idx_ff));
   assign before_cand = !have_cand_ff || (rd_ff.base < cand_base_ff) ||
                        ((rd_ff.base == cand_base_ff) && (idx_ff < cand_idx_ff));

   always_comb begin
      stat.is_delete  = (item_ff.req_type == sfa_pkg::REQ_DELETE);
      stat.idx_last   = (idx_ff == IDX_W'(SEGMENT_SLOTS - 1));
      stat.free_found = free_found_ff;
      stat.del_hit    = cur_valid && (rd_ff.owner == item_ff.owner_pid) &&
                        (rd_ff.ident == item_ff.seg_ident);
      stat.have_cand  = have_cand_ff;
      stat.slot_valid = cur_valid;
      stat.need_move  = (base_ext != cursor_ff);
      stat.out_free   = out_free;
      stat.nospace    = total_ff < {1'b0, item_ff.seg_size};
      stat.found      = found_ff;
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = idx_ff;
      wr_data = rd_ff;
      if (cmd.place) begin
         wr_en         = 1'b1;
         wr_addr       = free_idx_ff;
         wr_data.owner = item_ff.owner_pid;
         wr_data.ident = item_ff.seg_ident;
         wr_data.base  = best_base_ff;
         wr_data.len   = item_ff.seg_size;
      end else if (cmd.comp_step && cur_valid && stat.need_move) begin
         wr_en        = 1'b1;
         wr_data.base = cursor_ff[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.del_clr) begin
         valid_ff[idx_ff] <= 1'b0;
      end else if (cmd.place) begin
         valid_ff[free_idx_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff        <= '0;
         free_found_ff <= 1'b0;
      end else begin
         if (cmd.idx_clr) begin
            idx_ff <= '0;
         end else if (cmd.idx_inc) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if (cmd.latch) begin
            free_found_ff <= 1'b0;
         end else if (cmd.free_chk && !cur_valid && !free_found_ff) begin
            free_found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         item_ff <= req_data;
      end
      if (cmd.free_chk && !cur_valid && !free_found_ff) begin
         free_idx_ff <= idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff    <= '0;
         total_ff     <= '0;
         found_ff     <= 1'b0;
         have_prev_ff <= 1'b0;
         have_cand_ff <= 1'b0;
      end else begin
         if (cmd.scan_init || cmd.comp_init) begin
            cursor_ff <= '0;
         end else if (cmd.hole_seg) begin
            if (seg_end > cursor_ff) begin
               cursor_ff <= seg_end;
            end
         end else if (cmd.comp_step && cur_valid) begin
            cursor_ff <= cursor_ff + CUR_W'(rd_ff.len);
         end
         if (cmd.scan_init) begin
            total_ff     <= '0;
            found_ff     <= 1'b0;
            have_prev_ff <= 1'b0;
            have_cand_ff <= 1'b0;
         end else begin
            if (cmd.hole_seg || cmd.hole_tail) begin
               if (gap) begin
                  total_ff <= total_ff + 33'(hs);
               end
               if (fit && better) begin
                  found_ff <= 1'b1;
               end
            end
            if (cmd.hole_seg) begin
               have_prev_ff <= 1'b1;
            end
            if (cmd.pass_init) begin
               have_cand_ff <= 1'b0;
            end else if (cmd.pick_chk && cur_valid && after_prev && before_cand) begin
               have_cand_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if ((cmd.hole_seg || cmd.hole_tail) && fit && better) begin
         best_ff      <= hs;
         best_base_ff <= cursor_ff[31:0];
      end
      if (cmd.hole_seg) begin
         prev_base_ff <= cand_base_ff;
         prev_idx_ff  <= cand_idx_ff;
      end
      if (cmd.pick_chk && cur_valid && after_prev && before_cand) begin
         cand_base_ff <= rd_ff.base;
         cand_len_ff  <= rd_ff.len;
         cand_idx_ff  <= idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_ff.status <= cmd.emit_status;
         rsp_ff.last   <= (cmd.emit_status != sfa_pkg::ST_MOVED);
         if (cmd.emit_status == sfa_pkg::ST_MOVED) begin
            rsp_ff.seg_base   <= cursor_ff[31:0];
            rsp_ff.moved_from <= rd_ff.base;
            rsp_ff.moved_len  <= rd_ff.len;
         end else begin
            rsp_ff.seg_base   <= cmd.emit_base ? best_base_ff : '0;
            rsp_ff.moved_from <= '0;
            rsp_ff.moved_len  <= '0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ hdl/segment_fit_allocator.sv @@
`timescale 1ns / 1ps

// Segment table allocator. A create or delete request arrives on the req_
// channel (valid/stall) and produces one or more result items on rsp_.
// A delete gives one item: ok if an entry with matching owner and ident was
// freed, error otherwise. A create gives one final item (ok with the base,
// no space, or error) that may follow a run of moved items, one for each
// segment relocated by compaction; last marks the final item.
// A create first searches for a free slot, then walks the holes in base
// order by a min-search over the slot table through its single read port,
// one pass for each valid segment and one more. Compaction adds a pass
// over the slots and a second hole walk.
// One request is worked at a time; req_stall is high until the final item
// is loaded into the output register, which then frees the input side.
// A stall on rsp_ holds the output item and pauses compaction at the next move.
// Reset empties the table and loads memory_size 4096, fit_strategy best fit.
// Registers via csr_: 0x0 memory_size, 0x4 fit_strategy.
module segment_fit_allocator #(
   parameter int SEGMENT_SLOTS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  sfa_pkg::req_item_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output sfa_pkg::rsp_item_type rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [2:0]            csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   logic [31:0]       memory_size_ff;
   logic              fit_strategy_ff;
   logic              busy;
   sfa_pkg::cmd_type  cmd;
   sfa_pkg::stat_type stat;

   assign csr_pready = 1'b1;
   assign req_stall  = busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         memory_size_ff  <= sfa_pkg::MEMORY_SIZE_RESET;
         fit_strategy_ff <= sfa_pkg::FIT_BEST;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_paddr[2])
            sfa_pkg::REG_MEMORY_SIZE: memory_size_ff  <= csr_pwdata;
            sfa_pkg::REG_FIT_STRATEGY: fit_strategy_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         sfa_pkg::REG_MEMORY_SIZE: csr_prdata = memory_size_ff;
         sfa_pkg::REG_FIT_STRATEGY: csr_prdata = {31'd0, fit_strategy_ff};
         default: csr_prdata = '0;
      endcase
   end

   sfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .stat      (stat),
      .busy      (busy),
      .cmd       (cmd)
   );

   sfa_datapath #(
      .SEGMENT_SLOTS (SEGMENT_SLOTS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_data     (req_data),
      .memory_size  (memory_size_ff),
      .fit_strategy (fit_strategy_ff),
      .cmd          (cmd),
      .stat         (stat),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data)
   );

`ifndef NO_ASSERTIONS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("block took an item without going busy");

   a_last_marks_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last == (rsp_data.status != sfa_pkg::ST_MOVED)))
      else $error("last flag disagrees with status");

   a_move_not_final: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && (rsp_data.status == sfa_pkg::ST_MOVED)) |-> req_stall)
      else $error("moved item delivered while the block is idle");
`endif

endmodule

@@ test/sfa_checker.sv @@
`timescale 1ns / 1ps

module sfa_checker #(
   parameter int SEGMENT_SLOTS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  sfa_pkg::req_item_type req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  sfa_pkg::rsp_item_type rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [2:0]            csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output int                    fail_count,
   output int                    pending,
   output int                    rsp_seen
);

   logic [31:0] mem_size;
   logic        strategy;
   logic        used [SEGMENT_SLOTS];
   sfa_pkg::slot_entry_type tab [SEGMENT_SLOTS];
   sfa_pkg::rsp_item_type expected_rsps [$];

   // walk the holes in base order, with a running end that never moves back
   task automatic find_hole(input logic [31:0] need, output logic [63:0] free_total,
                            output logic found, output logic [31:0] where);
      int order [SEGMENT_SLOTS];
      int n;
      int j;
      logic [63:0] cursor;
      logic [63:0] best;
      logic [63:0] hs;
      logic [63:0] seg_end;
      logic have;
      n = 0;
      cursor = 0;
      best = 0;
      for (int i = 0; i < SEGMENT_SLOTS; i++) begin
         if (used[i]) begin
            j = n;
            while (j > 0 && tab[order[j-1]].base > tab[i].base) begin
               order[j] = order[j-1];
               j--;
            end
            order[j] = i;
            n++;
         end
      end
      free_total = 0;
      found = 0;
      where = 0;
      for (int i = 0; i <= n; i++) begin
         have = 0;
         hs = 0;
         if (i < n) begin
            seg_end = 64'(tab[order[i]].base) + 64'(tab[order[i]].len);
            if (64'(tab[order[i]].base) > cursor) begin
               hs = 64'(tab[order[i]].base) - cursor;
               have = 1;
            end
            if (have) begin
               free_total += hs;
               if (hs >= 64'(need) && (!found
                   || (strategy == sfa_pkg::FIT_BEST && hs < best)
                   || (strategy != sfa_pkg::FIT_BEST && hs > best))) begin
                  found = 1;
                  best = hs;
                  where = cursor[31:0];
               end
            end
            if (seg_end > cursor) cursor = seg_end;
         end else if (cursor < 64'(mem_size)) begin
            hs = 64'(mem_size) - cursor;
            free_total += hs;
            if (hs >= 64'(need) && (!found
                || (strategy == sfa_pkg::FIT_BEST && hs < best)
                || (strategy != sfa_pkg::FIT_BEST && hs > best))) begin
               found = 1;
               best = hs;
               where = cursor[31:0];
            end
         end
      end
   endtask

   function automatic sfa_pkg::rsp_item_type mk(sfa_pkg::status_type st, logic [31:0] b,
                                                logic [31:0] f, logic [31:0] l,
                                                logic lst);
      sfa_pkg::rsp_item_type r;
      r.status = st;
      r.seg_base = b;
      r.moved_from = f;
      r.moved_len = l;
      r.last = lst;
      return r;
   endfunction

   task automatic predict_request(input sfa_pkg::req_item_type q);
      int slot;
      logic [63:0] free_total;
      logic [63:0] cursor;
      logic found;
      logic [31:0] where;
      slot = -1;
      if (q.req_type == sfa_pkg::REQ_DELETE) begin
         for (int i = 0; i < SEGMENT_SLOTS; i++) begin
            if (slot < 0 && used[i] && tab[i].owner == q.owner_pid
                && tab[i].ident == q.seg_ident) slot = i;
         end
         if (slot >= 0) used[slot] = 0;
         expected_rsps.push_back(mk(slot >= 0 ? sfa_pkg::ST_OK : sfa_pkg::ST_ERROR,
                                    0, 0, 0, 1));
         return;
      end
      for (int i = SEGMENT_SLOTS - 1; i >= 0; i--) if (!used[i]) slot = i;
      if (slot < 0) begin
         expected_rsps.push_back(mk(sfa_pkg::ST_ERROR, 0, 0, 0, 1));
         return;
      end
      find_hole(q.seg_size, free_total, found, where);
      if (free_total < 64'(q.seg_size)) begin
         expected_rsps.push_back(mk(sfa_pkg::ST_NOSPACE, 0, 0, 0, 1));
         return;
      end
      if (!found) begin
         // compaction in slot order toward address zero
         cursor = 0;
         for (int i = 0; i < SEGMENT_SLOTS; i++) begin
            if (used[i]) begin
               if (64'(tab[i].base) != cursor) begin
                  expected_rsps.push_back(mk(sfa_pkg::ST_MOVED, cursor[31:0],
                                             tab[i].base, tab[i].len, 0));
                  tab[i].base = cursor[31:0];
               end
               cursor += 64'(tab[i].len);
            end
         end
         find_hole(q.seg_size, free_total, found, where);
         if (!found) begin
            expected_rsps.push_back(mk(sfa_pkg::ST_ERROR, 0, 0, 0, 1));
            return;
         end
      end
      used[slot] = 1;
      tab[slot].owner = q.owner_pid;
      tab[slot].ident = q.seg_ident;
      tab[slot].base = where;
      tab[slot].len = q.seg_size;
      expected_rsps.push_back(mk(sfa_pkg::ST_OK, where, 0, 0, 1));
   endtask

   always @(posedge clock) begin
      sfa_pkg::rsp_item_type e;
      if (reset) begin
         mem_size <= sfa_pkg::MEMORY_SIZE_RESET;
         strategy <= sfa_pkg::FIT_BEST;
         for (int i = 0; i < SEGMENT_SLOTS; i++) used[i] = 0;
         expected_rsps.delete();
         fail_count <= 0;
         rsp_seen <= 0;
         pending <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite) begin
            if (csr_paddr[2] == sfa_pkg::REG_MEMORY_SIZE) mem_size <= csr_pwdata;
            else strategy <= csr_pwdata[0];
         end
         if (req_valid && !req_stall) predict_request(req_data);
         if (rsp_valid && !rsp_stall) begin
            rsp_seen <= rsp_seen + 1;
            if (expected_rsps.size() == 0) begin
               $error("unexpected result item %p", rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               e = expected_rsps.pop_front();
               if (rsp_data != e) begin
                  fail_count <= fail_count + 1;
                  if (rsp_data.status != e.status)
                     $error("status: expected %0d actual %0d", e.status, rsp_data.status);
                  if (rsp_data.seg_base != e.seg_base)
                     $error("seg_base: expected %0h actual %0h", e.seg_base,
                            rsp_data.seg_base);
                  if (rsp_data.moved_from != e.moved_from)
                     $error("moved_from: expected %0h actual %0h", e.moved_from,
                            rsp_data.moved_from);
                  if (rsp_data.moved_len != e.moved_len)
                     $error("moved_len: expected %0h actual %0h", e.moved_len,
                            rsp_data.moved_len);
                  if (rsp_data.last != e.last)
                     $error("last: expected %0d actual %0d", e.last, rsp_data.last);
               end
            end
         end
         pending <= expected_rsps.size();
      end
   end

endmodule

@@ test/tb_segment_fit_allocator.sv @@
`timescale 1ns / 1ps

module tb_segment_fit_allocator;

   localparam int SLOTS = 16;
   localparam int IDLE_LIMIT = 40000;

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  req_valid = 0;
   logic                  req_stall;
   sfa_pkg::req_item_type req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 0;
   sfa_pkg::rsp_item_type rsp_data;
   logic                  csr_psel = 0;
   logic                  csr_penable = 0;
   logic                  csr_pwrite = 0;
   logic [2:0]            csr_paddr = '0;
   logic [31:0]           csr_pwdata = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;
   int                    fail_count;
   int                    pending;
   int                    rsp_seen;
   int                    idle_cycles = 0;
   int                    creates = 0;
   int                    deletes = 0;

   always #2 clock = ~clock;

   segment_fit_allocator #(.SEGMENT_SLOTS(SLOTS)) dut (.*);

   sfa_checker #(.SEGMENT_SLOTS(SLOTS)) checker_i (.*);

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // receiver stalls at random
   always @(posedge clock) begin
      if (reset) rsp_stall <= 0;
      else if ($urandom_range(0, 99) < 8) rsp_stall <= ($urandom_range(0, 3) != 0);
      else if ($urandom_range(0, 99) < 40) rsp_stall <= 0;
   end

   always @(posedge clock) begin
      if (req_valid && !req_stall || rsp_valid && !rsp_stall) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
         $display("watchdog: no progress");
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic csr_write(input logic addr_sel, input logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1;
      csr_penable <= 0;
      csr_pwrite <= 1;
      csr_paddr <= {addr_sel, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
   endtask

   // valid drops only when a gap follows, so back to back items keep it high
   task automatic send(input logic kind, input logic [15:0] pid, input logic [15:0] id,
                       input logic [31:0] size);
      int g;
      g = gap_length();
      if (g != 0) begin
         req_valid <= 0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1;
      req_data <= '{req_type: kind, owner_pid: pid, seg_ident: id, seg_size: size};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (kind == sfa_pkg::REQ_CREATE) creates++;
      else deletes++;
   endtask

   task automatic drain();
      req_valid <= 0;
      while (pending != 0) @(posedge clock);
      repeat (700) @(posedge clock);
   endtask

   // random create/delete traffic on a small id space so deletes usually hit
   task automatic random_phase(input int count, input int max_size);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) < 55)
            send(sfa_pkg::REQ_CREATE, 16'($urandom_range(0, 3)), 16'($urandom_range(0, 7)),
                 ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, max_size));
         else if ($urandom_range(0, 9) == 0)
            send(sfa_pkg::REQ_DELETE, 16'($urandom), 16'($urandom), $urandom);
         else
            send(sfa_pkg::REQ_DELETE, 16'($urandom_range(0, 3)), 16'($urandom_range(0, 7)),
                 $urandom);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 0;
      // directed: fill, fragment, force compaction, full table, not found
      send(sfa_pkg::REQ_CREATE, 16'hFFFF, 16'hFFFF, 32'd0);
      send(sfa_pkg::REQ_CREATE, 16'h0000, 16'h0000, 32'hFFFF_FFFF);
      send(sfa_pkg::REQ_DELETE, 16'h1234, 16'h5678, 32'd0);
      send(sfa_pkg::REQ_DELETE, 16'hFFFF, 16'hFFFF, 32'd0);
      for (int i = 0; i < 16; i++) send(sfa_pkg::REQ_CREATE, 16'd1, 16'(i), 32'd256);
      send(sfa_pkg::REQ_CREATE, 16'd1, 16'd99, 32'd1);
      for (int i = 0; i < 16; i += 2) send(sfa_pkg::REQ_DELETE, 16'd1, 16'(i), 32'd0);
      send(sfa_pkg::REQ_CREATE, 16'd2, 16'd0, 32'd1024);
      send(sfa_pkg::REQ_CREATE, 16'd2, 16'd1, 32'd4096);
      drain();
      csr_write(sfa_pkg::REG_FIT_STRATEGY, 32'hFFFF_FFFF);
      csr_write(sfa_pkg::REG_MEMORY_SIZE, 32'd2048);
      send(sfa_pkg::REQ_CREATE, 16'd3, 16'd0, 32'd0);
      send(sfa_pkg::REQ_CREATE, 16'd3, 16'd1, 32'd8);
      drain();
      csr_write(sfa_pkg::REG_MEMORY_SIZE, 32'hFFFF_FFFF);
      random_phase(60, 32'h7FFF_FFFF);
      drain();
      csr_write(sfa_pkg::REG_FIT_STRATEGY, 32'd0);
      csr_write(sfa_pkg::REG_MEMORY_SIZE, 32'd0);
      random_phase(20, 64);
      drain();
      csr_write(sfa_pkg::REG_MEMORY_SIZE, 32'd4096);
      random_phase(100, 600);
      drain();
      csr_write(sfa_pkg::REG_FIT_STRATEGY, 32'd1);
      csr_write(sfa_pkg::REG_MEMORY_SIZE, 32'd1000);
      random_phase(80, 200);
      drain();
      $display("covered %0d creates and %0d deletes with %0d result items,", creates,
               deletes, rsp_seen);
      $display("both fit strategies and memory sizes from zero to the full range");
      if (fail_count == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

endmodule
